// File: rtl/tween_timeline_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Tween timeline sequencer assertion macros
// Shared macros for the concurrent checks of the timeline sequencer.
// ----------------------------------------------------------------------------
`ifndef TWEEN_TIMELINE_SEQUENCER_DEFINES_SVH
`define TWEEN_TIMELINE_SEQUENCER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tween_timeline_sequencer: check failed");

// Consequent checked in the cycle after the antecedent.
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tween_timeline_sequencer: check failed");

`endif

// File: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// Tween timeline sequencer package
// Shared constants, codes and types of the timeline sequencer.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int ALU_W         = 33;
  localparam int APB_AW        = 5;
  localparam int APB_DW        = 32;
  localparam int IN_TDATA_W    = 16;
  localparam int IN_TUSER_W    = 2;
  localparam int OUT_TDATA_W   = 24;
  localparam int OUT_TUSER_W   = 10;
  localparam int PROG_W        = 17;

  localparam logic [31:0]       LOOPS_FOREVER = 32'hFFFF_FFFF;
  localparam logic [PROG_W-1:0] ONE_Q16       = 17'h1_0000;

  localparam logic [31:0] DURATION_RST   = 32'd500;
  localparam logic [15:0] TIME_SCALE_RST = 16'd256;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;
  localparam logic [1:0] FUNC_PAUSE = 2'd3;

  localparam logic [1:0] LOOP_SINGLE = 2'd0;
  localparam logic [1:0] LOOP_REPEAT = 2'd1;
  localparam logic [1:0] LOOP_YOYO   = 2'd2;

  localparam logic [2:0] RS_CREATED = 3'd0;
  localparam logic [2:0] RS_RUNNING = 3'd1;
  localparam logic [2:0] RS_PAUSED  = 3'd2;
  localparam logic [2:0] RS_STOPPED = 3'd3;
  localparam logic [2:0] RS_DONE    = 3'd4;

  localparam logic [2:0] REG_DURATION       = 3'd0;
  localparam logic [2:0] REG_START_DELAY    = 3'd1;
  localparam logic [2:0] REG_LOOP_MODE      = 3'd2;
  localparam logic [2:0] REG_LOOP_COUNT     = 3'd3;
  localparam logic [2:0] REG_START_REVERSED = 3'd4;
  localparam logic [2:0] REG_TIME_SCALE     = 3'd5;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             borrow;
  } alu_rsp_t;

  typedef struct packed {
    logic [2:0] run_state;
    logic       refused;
    logic       finished;
    logic       leg_done;
    logic       paused;
    logic       stopped;
    logic       started;
    logic       progress_valid;
  } out_user_t;

endpackage

// File: rtl/tts_alu.sv
// ----------------------------------------------------------------------------
// Tween timeline sequencer shared adder
// Add/subtract unit with borrow, shared by the sequencer's add, subtract and compare steps.
// ----------------------------------------------------------------------------
module tts_alu (
  input  tts_pkg::alu_req_t req_i,
  output tts_pkg::alu_rsp_t rsp_o
);
  import tts_pkg::*;

  logic [ALU_W-1:0] b_eff;
  logic [ALU_W:0]   total;

  assign b_eff = req_i.sub ? ~req_i.b : req_i.b;
  assign total = {1'b0, req_i.a} + {1'b0, b_eff} + (ALU_W + 1)'(req_i.sub);

  assign rsp_o.sum    = total[ALU_W-1:0];
  assign rsp_o.borrow = req_i.sub & ~total[ALU_W];

endmodule

// File: rtl/tween_timeline_sequencer.sv
// ----------------------------------------------------------------------------
// Tween timeline sequencer
// Linear animation timeline driven by tick, start, stop and pause requests.
// ----------------------------------------------------------------------------
// One request is taken at a time. Start, stop, pause and a tick that finds
// the run not running go from decode straight to the output state; a tick
// that is still used up by the start delay passes scale and delay; any
// other tick goes through advance, diff and compare, after a remain step
// when it also ends the start delay, then, inside a leg, through the 16
// single-bit steps of the progress division through the one shared 33-bit
// adder, then mirror, and leg at the leg end. The result sits in an output
// register, so the next request is accepted while it waits to be taken.
module tween_timeline_sequencer #(
  parameter int TIME_BITS = tts_pkg::TIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tts_pkg::APB_AW-1:0]       paddr,
  input  logic [tts_pkg::APB_DW-1:0]       pwdata,
  output logic [tts_pkg::APB_DW-1:0]       prdata,
  output logic                             pready,
  // Request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tts_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [15:0] delta
  input  logic [tts_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // [1:0] func
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tts_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [16:0] progress
  // [0] progress_valid, [1] started, [2] stopped, [3] paused, [4] leg_done,
  // [5] finished, [6] refused, [9:7] run_state
  output logic [tts_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
  import tts_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DECODE  = 4'd1;
  localparam logic [3:0] ST_SCALE   = 4'd2;
  localparam logic [3:0] ST_DELAY   = 4'd3;
  localparam logic [3:0] ST_REMAIN  = 4'd4;
  localparam logic [3:0] ST_ADVANCE = 4'd5;
  localparam logic [3:0] ST_DIFF    = 4'd6;
  localparam logic [3:0] ST_CMP     = 4'd7;
  localparam logic [3:0] ST_DIV     = 4'd8;
  localparam logic [3:0] ST_MIRROR  = 4'd9;
  localparam logic [3:0] ST_LEG     = 4'd10;
  localparam logic [3:0] ST_OUT     = 4'd11;

  function automatic logic [31:0] loaded_loops(logic [1:0] mode, logic [31:0] count);
    logic [31:0] r;
    r = '0;
    if (mode == LOOP_REPEAT || mode == LOOP_YOYO) begin
      r = (count == '0) ? LOOPS_FOREVER : count;
    end
    return r;
  endfunction

  // Configuration registers
  logic [31:0] duration_q;
  logic [31:0] start_delay_q;
  logic [1:0]  loop_mode_q;
  logic [31:0] loop_count_q;
  logic        start_reversed_q;
  logic [15:0] tick_scale_q;

  // Timeline state
  logic [2:0]           mode_state_q;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] leg_start_q;
  logic [31:0]          delay_left_q;
  logic                 rev_q;
  logic [31:0]          loops_left_q;

  // Sequencer and work registers
  logic [3:0]           state_q;
  logic [3:0]           state_d;
  logic [1:0]           func_q;
  logic [15:0]          delta_q;
  logic [23:0]          elapsed_q;
  logic [TIME_BITS-1:0] d_q;
  logic [31:0]          rem_q;
  logic [3:0]           cnt_q;
  logic                 leg_end_q;
  logic [PROG_W-1:0]    prog_q;
  out_user_t            res_q;

  // Output register
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_tdata_q;
  logic [OUT_TUSER_W-1:0] m_tuser_q;

  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;
  logic [31:0] scale_prod;
  logic [32:0] rem_shift;
  logic        delay_gt;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic        in_take;
  logic        out_load;
  logic        running;
  logic        looped;
  logic        rev_new;
  logic [31:0] loops_new;
  logic        finish;
  out_user_t   out_user;
  out_user_t   dec_res;

  tts_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign cfg_idx       = paddr[APB_AW-1:2];
  assign cfg_we        = psel & penable & pwrite;
  assign pready        = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_take       = s_axis_tvalid & s_axis_tready;
  assign out_load      = (state_q == ST_OUT) & (~m_valid_q | m_axis_tready);
  assign running       = (mode_state_q == RS_RUNNING);
  assign scale_prod    = 32'(delta_q) * 32'(tick_scale_q);
  assign rem_shift     = {rem_q, 1'b0};
  assign delay_gt      = ~alu_rsp.borrow & (alu_rsp.sum[31:0] != '0);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_DURATION:       prdata = duration_q;
      REG_START_DELAY:    prdata = start_delay_q;
      REG_LOOP_MODE:      prdata = APB_DW'(loop_mode_q);
      REG_LOOP_COUNT:     prdata = loop_count_q;
      REG_START_REVERSED: prdata = APB_DW'(start_reversed_q);
      REG_TIME_SCALE:     prdata = APB_DW'(tick_scale_q);
      default:            prdata = '0;
    endcase
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_req = '0;
    unique case (state_q)
      ST_DELAY: begin
        alu_req.a   = ALU_W'(delay_left_q);
        alu_req.b   = ALU_W'(elapsed_q);
        alu_req.sub = 1'b1;
      end
      ST_REMAIN: begin
        alu_req.a   = ALU_W'(elapsed_q);
        alu_req.b   = ALU_W'(delay_left_q);
        alu_req.sub = 1'b1;
      end
      ST_ADVANCE: begin
        alu_req.a   = ALU_W'(now_q);
        alu_req.b   = ALU_W'(elapsed_q);
      end
      ST_DIFF: begin
        alu_req.a   = ALU_W'(now_q);
        alu_req.b   = ALU_W'(leg_start_q);
        alu_req.sub = 1'b1;
      end
      ST_CMP: begin
        alu_req.a   = ALU_W'(d_q);
        alu_req.b   = ALU_W'(duration_q);
        alu_req.sub = 1'b1;
      end
      ST_DIV: begin
        alu_req.a   = rem_shift;
        alu_req.b   = ALU_W'(duration_q);
        alu_req.sub = 1'b1;
      end
      ST_MIRROR: begin
        alu_req.a   = ALU_W'(ONE_Q16);
        alu_req.b   = ALU_W'(prog_q);
        alu_req.sub = 1'b1;
      end
      ST_LEG: begin
        alu_req.a   = ALU_W'(loops_left_q);
        alu_req.b   = ALU_W'(1'b1);
        alu_req.sub = 1'b1;
      end
      default: alu_req = '0;
    endcase
  end

  // Result flags of a start, stop or pause request.
  always_comb begin
    dec_res = '0;
    unique case (func_q)
      FUNC_START: begin
        if (!running) begin
          dec_res.started        = 1'b1;
          dec_res.progress_valid = 1'b1;
        end
      end
      FUNC_STOP: begin
        if (running) begin
          dec_res.stopped        = 1'b1;
          dec_res.progress_valid = 1'b1;
        end else begin
          dec_res.refused = 1'b1;
        end
      end
      FUNC_PAUSE: begin
        if (running) begin
          dec_res.paused = 1'b1;
        end else begin
          dec_res.refused = 1'b1;
        end
      end
      default: dec_res = '0;
    endcase
  end

  // Loop bookkeeping at the end of a leg.
  always_comb begin
    looped    = 1'b0;
    rev_new   = rev_q;
    loops_new = loops_left_q;
    case (loop_mode_q)
      LOOP_REPEAT: begin
        if (loops_left_q != '0) begin
          looped    = 1'b1;
          loops_new = alu_rsp.sum[31:0];
        end
      end
      LOOP_YOYO: begin
        if (loops_left_q != '0) begin
          looped  = 1'b1;
          rev_new = ~rev_q;
          if (!rev_new) begin
            loops_new = alu_rsp.sum[31:0];
          end
        end
      end
      default: looped = 1'b0;
    endcase
    if (looped && loops_new == '0 && loop_count_q == '0) begin
      loops_new = LOOPS_FOREVER;
    end
    finish = (loops_new == '0) ||
             !(loop_mode_q == LOOP_REPEAT || loop_mode_q == LOOP_YOYO);
  end

  always_comb begin
    out_user           = res_q;
    out_user.run_state = mode_state_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_take) state_d = ST_DECODE;
      ST_DECODE:  state_d = (func_q == FUNC_TICK && running) ? ST_SCALE : ST_OUT;
      ST_SCALE:   state_d = ST_DELAY;
      ST_DELAY: begin
        if (delay_left_q == '0) begin
          state_d = ST_ADVANCE;
        end else begin
          state_d = delay_gt ? ST_OUT : ST_REMAIN;
        end
      end
      ST_REMAIN:  state_d = ST_ADVANCE;
      ST_ADVANCE: state_d = ST_DIFF;
      ST_DIFF:    state_d = ST_CMP;
      ST_CMP:     state_d = alu_rsp.borrow ? ST_DIV : ST_MIRROR;
      ST_DIV:     if (cnt_q == 4'd15) state_d = ST_MIRROR;
      ST_MIRROR:  state_d = leg_end_q ? ST_LEG : ST_OUT;
      ST_LEG:     state_d = ST_OUT;
      ST_OUT:     if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q  <= s_axis_tuser;
      delta_q <= s_axis_tdata;
    end
    if (out_load) begin
      m_tdata_q <= OUT_TDATA_W'(prog_q);
      m_tuser_q <= out_user;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q       <= DURATION_RST;
      start_delay_q    <= '0;
      loop_mode_q      <= LOOP_SINGLE;
      loop_count_q     <= '0;
      start_reversed_q <= 1'b0;
      tick_scale_q     <= TIME_SCALE_RST;
      mode_state_q     <= RS_CREATED;
      now_q            <= '0;
      leg_start_q      <= '0;
      delay_left_q     <= '0;
      rev_q            <= 1'b0;
      loops_left_q     <= '0;
      elapsed_q        <= '0;
      d_q              <= '0;
      rem_q            <= '0;
      cnt_q            <= '0;
      leg_end_q        <= 1'b0;
      prog_q           <= '0;
      res_q            <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DURATION: duration_q <= pwdata;
        REG_START_DELAY: begin
          start_delay_q <= pwdata;
          delay_left_q  <= pwdata;
        end
        REG_LOOP_MODE: begin
          loop_mode_q  <= pwdata[1:0];
          loops_left_q <= loaded_loops(pwdata[1:0], loop_count_q);
        end
        REG_LOOP_COUNT: begin
          loop_count_q <= pwdata;
          loops_left_q <= loaded_loops(loop_mode_q, pwdata);
        end
        REG_START_REVERSED: begin
          start_reversed_q <= pwdata[0];
          rev_q            <= pwdata[0];
        end
        REG_TIME_SCALE: tick_scale_q <= pwdata[15:0];
        default: duration_q <= duration_q;
      endcase
    end else begin
      unique case (state_q)
        ST_DECODE: begin
          res_q     <= dec_res;
          prog_q    <= '0;
          leg_end_q <= 1'b0;
          unique case (func_q)
            FUNC_START: begin
              if (!running) begin
                if (mode_state_q == RS_DONE) begin
                  now_q        <= '0;
                  leg_start_q  <= '0;
                  rev_q        <= start_reversed_q;
                  loops_left_q <= loaded_loops(loop_mode_q, loop_count_q);
                end
                mode_state_q <= RS_RUNNING;
              end
            end
            FUNC_STOP: begin
              if (running) begin
                now_q        <= '0;
                leg_start_q  <= '0;
                rev_q        <= start_reversed_q;
                mode_state_q <= RS_STOPPED;
              end
            end
            FUNC_PAUSE: begin
              if (running) begin
                mode_state_q <= RS_PAUSED;
              end
            end
            default: mode_state_q <= mode_state_q;
          endcase
        end
        ST_SCALE: elapsed_q <= scale_prod[31:8];
        ST_DELAY: begin
          if (delay_left_q != '0 && delay_gt) begin
            delay_left_q <= alu_rsp.sum[31:0];
          end
        end
        ST_REMAIN: begin
          elapsed_q    <= alu_rsp.sum[23:0];
          delay_left_q <= '0;
          now_q        <= '0;
          leg_start_q  <= '0;
        end
        ST_ADVANCE: now_q <= alu_rsp.sum[TIME_BITS-1:0];
        ST_DIFF:    d_q   <= alu_rsp.sum[TIME_BITS-1:0];
        ST_CMP: begin
          res_q.progress_valid <= 1'b1;
          leg_end_q            <= ~alu_rsp.borrow;
          cnt_q                <= '0;
          rem_q                <= 32'(d_q);
          prog_q               <= alu_rsp.borrow ? '0 : ONE_Q16;
        end
        ST_DIV: begin
          cnt_q  <= cnt_q + 4'd1;
          prog_q <= {prog_q[PROG_W-2:0], ~alu_rsp.borrow};
          rem_q  <= alu_rsp.borrow ? rem_shift[31:0] : alu_rsp.sum[31:0];
        end
        ST_MIRROR: begin
          if (rev_q) begin
            prog_q <= alu_rsp.sum[PROG_W-1:0];
          end
        end
        ST_LEG: begin
          loops_left_q <= loops_new;
          rev_q        <= rev_new;
          if (looped) begin
            leg_start_q <= now_q;
          end
          if (finish) begin
            mode_state_q   <= RS_DONE;
            res_q.finished <= 1'b1;
          end else begin
            res_q.leg_done <= looped;
          end
        end
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/tts_checker.sv
// ----------------------------------------------------------------------------
// Tween timeline sequencer checker
// Port-level checks of the timeline sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "tween_timeline_sequencer_defines.svh"

module tts_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tts_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [tts_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import tts_pkg::*;

  // A request is worked on before the next is taken.
  `TTS_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  `TTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Progress is zero unless it carries a new value.
  `TTS_ASSERT_SAME(a_prog_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)

  `TTS_ASSERT_SAME(a_prog_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[16:0] <= ONE_Q16 && m_axis_tdata[23:17] == '0)

  // A finished run always reports the done state.
  `TTS_ASSERT_SAME(a_fin_done, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[5], m_axis_tuser[9:7] == RS_DONE)

endmodule

bind tween_timeline_sequencer tts_checker u_tts_checker (.*);
